FILE: hw/rtl/efe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efe_pkg
// Shared types and constants for the escaped frame encoder: the command
// record passed from the front end to the emitter, and the queue sizing.
// ----------------------------------------------------------------------------
package efe_pkg;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7e;
    localparam logic [7:0]  ESC_BYTE   = 8'h7d;
    localparam logic [7:0]  ESC_FOR_7D = 8'h01;
    localparam logic [7:0]  ESC_FOR_7E = 8'h02;
    localparam logic [15:0] CRC_INIT   = 16'hffff;
    localparam logic [15:0] CRC_POLY   = 16'ha001;

    localparam int MAX_FRAME_LEN = 1024;
    localparam int CNT_W         = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DIS  = 2'd1,
        KIND_LONG = 2'd2
    } t_kind;

    // One accepted item, fully classified; crc is the value after this byte (unchanged for an over-length byte)
    typedef struct packed {
        logic        open;
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc;
    } t_cmd;

endpackage

FILE: hw/rtl/efe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efe_front
// Accepts input transactions, keeps the frame state and running CRC, and
// turns each item into a command for the emitter.
// ----------------------------------------------------------------------------
module efe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    input  logic          i_q_full,
    output logic          o_push,
    output efe_pkg::t_cmd o_cmd
);
    import efe_pkg::*;

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_FRAME_LEN);

    logic             r_enable;
    logic             r_in_frame, n_in_frame;
    logic [15:0]      r_crc, n_crc;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [15:0]      crc_base, crc_new;
    logic [CNT_W-1:0] cnt_base;
    logic             accept;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    // a closed frame restarts from the initial CRC and an empty count
    assign crc_base = r_in_frame ? r_crc : CRC_INIT;
    assign cnt_base = r_in_frame ? r_cnt : '0;
    assign crc_new  = crc_byte(crc_base, i_data_byte);

    always_comb begin
        o_cmd      = '0;
        o_cmd.data = i_data_byte;
        o_cmd.last = i_last_byte;
        n_in_frame = r_in_frame;
        n_crc      = r_crc;
        n_cnt      = r_cnt;
        if (!r_enable) begin
            o_cmd.kind = KIND_DIS;
            o_cmd.last = 1'b0;
        end else begin
            o_cmd.open = !r_in_frame;
            if (cnt_base < MAX_LEN) begin
                o_cmd.kind = KIND_DATA;
                o_cmd.crc  = crc_new;
                n_crc      = crc_new;
                n_cnt      = cnt_base + 1'b1;
            end else begin
                o_cmd.kind = KIND_LONG;
                o_cmd.crc  = crc_base;
                n_crc      = crc_base;
                n_cnt      = cnt_base;
            end
            n_in_frame = 1'b1;
            if (i_last_byte) begin
                n_in_frame = 1'b0;
                n_crc      = CRC_INIT;
                n_cnt      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_in_frame <= 1'b0;
            r_crc      <= CRC_INIT;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (accept) begin
                r_in_frame <= n_in_frame;
                r_crc      <= n_crc;
                r_cnt      <= n_cnt;
            end
        end
    end

endmodule

FILE: hw/rtl/efe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efe_queue
// Short command FIFO between the front end and the emitter.
// ----------------------------------------------------------------------------
module efe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  efe_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output efe_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);
    import efe_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/efe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efe_back
// Emitter: walks each queued command through its output bytes (opening flag, escaped
// data or status beat, escaped CRC, closing flag), one result per cycle when not stalled.
// ----------------------------------------------------------------------------
module efe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  efe_pkg::t_cmd i_head,
    input  logic          i_q_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_last_of_run,
    output logic          o_end_of_frame,
    output logic [1:0]    o_status
);
    import efe_pkg::*;

    typedef enum logic [7:0] {
        S_OPEN     = 8'b0000_0001,
        S_BODY     = 8'b0000_0010,
        S_BODY_ESC = 8'b0000_0100,
        S_HI       = 8'b0000_1000,
        S_HI_ESC   = 8'b0001_0000,
        S_LO       = 8'b0010_0000,
        S_LO_ESC   = 8'b0100_0000,
        S_CLOSE    = 8'b1000_0000
    } t_step;

    logic       r_busy;
    t_step      r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_eof;
    logic [1:0] r_status;

    t_step      cur, nxt;
    logic [7:0] e_byte;
    logic       e_eof, e_done;
    t_status    e_status;
    logic       load, fire;

    function automatic logic special(input logic [7:0] b);
        return (b == ESC_BYTE) || (b == FLAG_BYTE);
    endfunction

    function automatic logic [7:0] esc_code(input logic [7:0] b);
        return (b == ESC_BYTE) ? ESC_FOR_7D : ESC_FOR_7E;
    endfunction

    assign cur  = r_busy ? r_step : (i_head.open ? S_OPEN : S_BODY);
    assign load = !r_valid || i_ready;
    assign fire = load && !i_q_empty;

    always_comb begin
        e_byte   = 8'h00;
        e_eof    = 1'b0;
        e_status = ST_OK;
        e_done   = 1'b0;
        nxt      = S_BODY;
        unique case (cur)
            S_OPEN: begin
                e_byte = FLAG_BYTE;
                nxt    = S_BODY;
            end
            S_BODY: begin
                unique case (i_head.kind)
                    KIND_DIS: begin
                        e_status = ST_DISABLED;
                        e_done   = 1'b1;
                    end
                    KIND_LONG: begin
                        e_status = ST_TOO_LONG;
                        e_done   = !i_head.last;
                        nxt      = S_HI;
                    end
                    default: begin
                        if (special(i_head.data)) begin
                            e_byte = ESC_BYTE;
                            nxt    = S_BODY_ESC;
                        end else begin
                            e_byte = i_head.data;
                            e_done = !i_head.last;
                            nxt    = S_HI;
                        end
                    end
                endcase
            end
            S_BODY_ESC: begin
                e_byte = esc_code(i_head.data);
                e_done = !i_head.last;
                nxt    = S_HI;
            end
            S_HI: begin
                if (special(i_head.crc[15:8])) begin
                    e_byte = ESC_BYTE;
                    nxt    = S_HI_ESC;
                end else begin
                    e_byte = i_head.crc[15:8];
                    nxt    = S_LO;
                end
            end
            S_HI_ESC: begin
                e_byte = esc_code(i_head.crc[15:8]);
                nxt    = S_LO;
            end
            S_LO: begin
                if (special(i_head.crc[7:0])) begin
                    e_byte = ESC_BYTE;
                    nxt    = S_LO_ESC;
                end else begin
                    e_byte = i_head.crc[7:0];
                    nxt    = S_CLOSE;
                end
            end
            S_LO_ESC: begin
                e_byte = esc_code(i_head.crc[7:0]);
                nxt    = S_CLOSE;
            end
            S_CLOSE: begin
                e_byte = FLAG_BYTE;
                e_eof  = 1'b1;
                e_done = 1'b1;
            end
            default: begin
                e_done = 1'b1;
            end
        endcase
    end

    assign o_pop = fire && e_done;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte   <= e_byte;
            r_last   <= e_done;
            r_eof    <= e_eof;
            r_status <= e_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= S_OPEN;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            if (fire) begin
                r_busy <= !e_done;
                r_step <= nxt;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_byte;
    assign o_last_of_run  = r_last;
    assign o_end_of_frame = r_eof;
    assign o_status       = r_status;

endmodule

FILE: hw/rtl/escaped_frame_encoder_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_encoder_crc16
// Byte-stuffing framer with CRC-16/MODBUS: opening and closing 0x7e flags,
// 0x7d/0x7e escaped as 7d 01 / 7d 02, CRC high then low byte before close.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_data_byte, i_last_byte
//   output   out        o_valid / i_ready    o_out_byte, o_last_of_run,
//                                            o_end_of_frame, o_status
//   config   in         i_cfg_wr_en          i_cfg_wr_data (enable)
//
// Input is taken one transaction per cycle while the 4-entry command queue
// has room; the emitter gives one output byte per cycle while i_ready does
// not hold it back, and an item takes one output beat per byte it yields.
// An input passes through the command queue and then the output register. Reset
// (synchronous, low) clears the frame state, the queue and the output register.
// ----------------------------------------------------------------------------
module escaped_frame_encoder_crc16 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_frame,
    output logic [1:0] o_status
);
    import efe_pkg::*;

    t_cmd push_cmd, head_cmd;
    logic push, pop, q_empty, q_full;

    efe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    efe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    efe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_cmd),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame),
        .o_status       (o_status)
    );

endmodule

FILE: tb/sv/escaped_frame_encoder_crc16_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_encoder_crc16_tb
// Self-checking bench for the byte-stuffing framer. Frames of bytes are pushed
// through the valid/ready input, the flagged and escaped stream with its
// CRC-16/MODBUS trailer is predicted per transaction, and every output
// transaction is checked in order under varying sender gaps and back-pressure.
// ----------------------------------------------------------------------------
import efe_pkg::*;

typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_frame;
    t_status    status;
} t_framed_beat;

class frame_scoreboard;
    t_framed_beat     beats_due[$];
    t_framed_beat     held;
    bit               have_held;
    logic             enable;
    logic             in_frame;
    logic [15:0]      crc_accum;
    logic [CNT_W-1:0] byte_count;
    int               beats_seen;
    int               errors;

    function new();
        have_held  = 1'b0;
        enable     = 1'b0;
        in_frame   = 1'b0;
        crc_accum  = CRC_INIT;
        byte_count = '0;
        beats_seen = 0;
        errors     = 0;
    endfunction

    function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
        logic [15:0] c;
        int          i;
        c = crc ^ {8'h00, data};
        for (i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // the newest beat is held back so the final one of a run can be marked
    function void emit(logic [7:0] b, logic eof, t_status st);
        if (have_held) begin
            beats_due.push_back(held);
        end
        held      = '{b, 1'b0, eof, st};
        have_held = 1'b1;
    endfunction

    function void emit_escaped(logic [7:0] b);
        if (b == ESC_BYTE) begin
            emit(ESC_BYTE, 1'b0, ST_OK);
            emit(ESC_FOR_7D, 1'b0, ST_OK);
        end else if (b == FLAG_BYTE) begin
            emit(ESC_BYTE, 1'b0, ST_OK);
            emit(ESC_FOR_7E, 1'b0, ST_OK);
        end else begin
            emit(b, 1'b0, ST_OK);
        end
    endfunction

    function void note_item(logic [7:0] data, logic last);
        if (!enable) begin
            emit(8'h00, 1'b0, ST_DISABLED);
        end else begin
            if (!in_frame) begin
                emit(FLAG_BYTE, 1'b0, ST_OK);
                in_frame   = 1'b1;
                crc_accum  = CRC_INIT;
                byte_count = '0;
            end
            if (byte_count < MAX_FRAME_LEN) begin
                crc_accum  = crc_update(crc_accum, data);
                emit_escaped(data);
                byte_count = byte_count + 1'b1;
            end else begin
                emit(8'h00, 1'b0, ST_TOO_LONG);
            end
            if (last) begin
                emit_escaped(crc_accum[15:8]);
                emit_escaped(crc_accum[7:0]);
                emit(FLAG_BYTE, 1'b1, ST_OK);
                in_frame   = 1'b0;
                crc_accum  = CRC_INIT;
                byte_count = '0;
            end
        end
        held.last_of_run = 1'b1;
        beats_due.push_back(held);
        have_held = 1'b0;
    endfunction

    task report(string msg);
        if (errors < 40) begin
            $display("MISMATCH: %s", msg);
        end
        errors++;
    endtask

    task check_result(logic [7:0] ob, logic lor, logic eof, logic [1:0] st);
        t_framed_beat want;
        if (beats_due.size() == 0) begin
            report($sformatf("result %0d (byte %02h) with nothing outstanding", beats_seen, ob));
        end else begin
            want = beats_due.pop_front();
            if (ob !== want.out_byte) begin
                report($sformatf("result %0d out_byte %02h, want %02h",
                                 beats_seen, ob, want.out_byte));
            end
            if (lor !== want.last_of_run) begin
                report($sformatf("result %0d last_of_run %b, want %b",
                                 beats_seen, lor, want.last_of_run));
            end
            if (eof !== want.end_of_frame) begin
                report($sformatf("result %0d end_of_frame %b, want %b",
                                 beats_seen, eof, want.end_of_frame));
            end
            if (st !== want.status) begin
                report($sformatf("result %0d status %0d, want %0d",
                                 beats_seen, st, want.status));
            end
        end
        beats_seen++;
    endtask
endclass

module escaped_frame_encoder_crc16_tb;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int PHASE_ITEMS      = 80;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_data_byte   = 8'h00;
    logic       i_last_byte   = 1'b0;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_end_of_frame;
    logic [1:0] o_status;

    int idle_pct  = 0;
    int stall_pct = 0;

    frame_scoreboard framer_sb = new();

    escaped_frame_encoder_crc16 DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("escaped_frame_encoder_crc16_tb failed");
        $finish;
    end

    // output back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            framer_sb.check_result(o_out_byte, o_last_of_run, o_end_of_frame, o_status);
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return ESC_BYTE;
            1: return FLAG_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // first byte whose one-byte frame gives the target in the chosen CRC half
    function automatic logic [7:0] pick_crc_byte(bit hi, logic [7:0] target);
        logic [15:0] c;
        int          b;
        for (b = 0; b < 256; b++) begin
            c = framer_sb.crc_update(CRC_INIT, 8'(b));
            if ((hi ? c[15:8] : c[7:0]) == target) begin
                return 8'(b);
            end
        end
        return 8'h00;
    endfunction

    task automatic send_item(logic [7:0] data, logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        framer_sb.note_item(data, last);
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (framer_sb.beats_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_enable(logic value);
        wait_until_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en      <= 1'b0;
        framer_sb.enable  = value;
    endtask

    task automatic send_frame(int len);
        int k;
        for (k = 0; k < len; k++) begin
            send_item(rand_byte(), k == len - 1);
        end
    endtask

    task automatic run_phase(int idle, int stall, bit pause_midway);
        int sent;
        int len;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 85) begin
                len = $urandom_range(1, 12);
                send_frame(len);
                sent += len;
            end else begin
                // stray transaction: may open a frame or close one early
                send_item(rand_byte(), 1'($urandom_range(1)));
                sent++;
            end
            if (pause_midway && sent >= PHASE_ITEMS / 2) begin
                wait_until_drained();
                pause_midway = 1'b0;
            end
        end
        // short disabled stretch; an open frame must carry on afterwards
        write_enable(1'b0);
        repeat ($urandom_range(1, 4)) send_item(rand_byte(), 1'($urandom_range(1)));
        write_enable(1'b1);
    endtask

    initial begin
        int k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled out of reset
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        write_enable(1'b1);

        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(ESC_BYTE, 1'b0);
        send_item(FLAG_BYTE, 1'b0);
        send_item(8'h55, 1'b1);

        // one-byte frames whose CRC bytes need escaping
        send_item(pick_crc_byte(1'b1, FLAG_BYTE), 1'b1);
        send_item(pick_crc_byte(1'b1, ESC_BYTE), 1'b1);
        send_item(pick_crc_byte(1'b0, FLAG_BYTE), 1'b1);
        send_item(pick_crc_byte(1'b0, ESC_BYTE), 1'b1);

        // frame held open across a disabled stretch
        send_item(8'h11, 1'b0);
        send_item(8'h22, 1'b0);
        write_enable(1'b0);
        send_item(FLAG_BYTE, 1'b1);
        send_item(8'h33, 1'b0);
        write_enable(1'b1);
        send_item(8'h44, 1'b1);

        send_item(FLAG_BYTE, 1'b0);
        send_item(ESC_BYTE, 1'b0);
        send_item(FLAG_BYTE, 1'b1);

        run_phase(0, 0, 1'b0);
        run_phase(74, 0, 1'b1);
        run_phase(0, 74, 1'b0);
        run_phase(36, 36, 1'b0);

        i_valid <= 1'b0;
        k = 0;
        while (framer_sb.beats_due.size() != 0 && k < DRAIN_LIMIT) begin
            @(posedge i_clk);
            k++;
        end
        repeat (8) @(posedge i_clk);
        if (framer_sb.beats_due.size() != 0) begin
            framer_sb.report($sformatf("%0d results never arrived", framer_sb.beats_due.size()));
        end

        if (framer_sb.errors == 0) begin
            $display("escaped_frame_encoder_crc16_tb passed");
        end else begin
            $display("escaped_frame_encoder_crc16_tb failed");
        end
        $finish;
    end

endmodule
